[design/aes_pkg.sv]
// Package with AES payload types, register indexes, state codes and round functions.
`default_nettype none
package aes_pkg;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        first_block;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } aes_out_t;

  localparam logic [2:0] REG_KEY_HIGH  = 3'd0;
  localparam logic [2:0] REG_KEY_LOW   = 3'd1;
  localparam logic [2:0] REG_IV_HIGH   = 3'd2;
  localparam logic [2:0] REG_IV_LOW    = 3'd3;
  localparam logic [2:0] REG_CHAINING  = 3'd4;
  localparam logic [2:0] REG_DIRECTION = 3'd5;

  typedef enum logic [1:0] {
    ST_KEYEXP,
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } aes_state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] subst_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Forward round body: SubBytes, ShiftRows and optionally MixColumns.
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic do_mix);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = SBOX[s[127-8*i -: 8]];
    for (int c = 0; c < 4; c++)
      for (int k = 0; k < 4; k++) t[k+4*c] = b[k+4*((c+k)%4)];
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      if (do_mix) begin
        t[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        t[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        t[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        t[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
    return r;
  endfunction

  // Inverse round body: optional InvMixColumns, InvShiftRows, InvSubBytes.
  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic do_mix);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, u, v;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    if (do_mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = b[4*c]; a1 = b[4*c+1]; a2 = b[4*c+2]; a3 = b[4*c+3];
        // Preprocess step turns InvMixColumns into a plain MixColumns.
        u = xtime(xtime(a0 ^ a2));
        v = xtime(xtime(a1 ^ a3));
        a0 = a0 ^ u; a1 = a1 ^ v; a2 = a2 ^ u; a3 = a3 ^ v;
        b[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        b[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        b[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        b[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    for (int c = 0; c < 4; c++)
      for (int k = 0; k < 4; k++) t[k+4*((c+k)%4)] = b[k+4*c];
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = INV_SBOX[t[i]];
    return r;
  endfunction

endpackage
`default_nettype wire

[design/aes128_block_cipher_ecb_cbc.sv]
// AES-128 ECB/CBC engine with one shared round unit and an iterative key schedule.
//
//  channel | signals                     | direction
//  in      | in_valid/in_ready/in_data   | request in
//  out     | out_valid/out_ready/out_data| result out
//  cfg     | cfg_valid/cfg_ready/cfg_index/cfg_data | register write in
//
// out_valid rises once an accepted request has passed the initial key
// addition and ten rounds through the shared round unit. With out_ready
// high the result leaves on the next edge. After reset and after each key
// write the schedule is rebuilt (one load plus one word per cycle) while
// in_ready stays low. The result register holds while out_ready is low; the
// next request is taken once the result is delivered.
`default_nettype none
module aes128_block_cipher_ecb_cbc (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  aes_pkg::aes_in_t in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output aes_pkg::aes_out_t     out_data,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [2:0]            cfg_index,
  input  wire  [63:0]           cfg_data
);
  import aes_pkg::*;

  logic [63:0] key_high_r, key_low_r, iv_high_r, iv_low_r;
  logic        chaining_r, direction_r;
  logic [127:0] rk_mem [11];
  logic [127:0] chain_r, chain_nxt;
  logic [127:0] state_r, state_nxt;
  logic [127:0] in_blk_r, in_blk_nxt;
  logic [127:0] prev_r, prev_nxt;
  logic [127:0] rkey_r;
  aes_state_t  st_r, st_nxt;
  logic [3:0]  rnd_r, rnd_nxt;
  logic [5:0]  kidx_r, kidx_nxt;
  logic [31:0] w1_r, w2_r, w3_r, w4_r;
  logic [7:0]  rc_r;
  logic [31:0] kword;
  logic [3:0]  rk_sel;
  logic [127:0] round_out;
  logic        key_write;

  assign cfg_ready = 1'b1;
  assign key_write = cfg_valid && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0; key_low_r <= '0; iv_high_r <= '0; iv_low_r <= '0;
      chaining_r <= 1'b0; direction_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_HIGH:  key_high_r <= cfg_data;
        REG_KEY_LOW:   key_low_r <= cfg_data;
        REG_IV_HIGH:   iv_high_r <= cfg_data;
        REG_IV_LOW:    iv_low_r <= cfg_data;
        REG_CHAINING:  chaining_r <= cfg_data[0];
        REG_DIRECTION: direction_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Key schedule: the last four words slide as one new word is made each cycle.
  assign kword = w1_r ^ ((kidx_r[1:0] == 2'd0) ?
                 (subst_word({w4_r[23:0], w4_r[31:24]}) ^ {rc_r, 24'h0}) : w4_r);

  // Each round key is one 128-bit entry; word k of it lands in its own slice.
  always_ff @(posedge clk) begin
    if (st_r == ST_KEYEXP) begin
      if (kidx_r == 6'd0) begin
        w1_r <= key_high_r[63:32]; w2_r <= key_high_r[31:0];
        w3_r <= key_low_r[63:32];  w4_r <= key_low_r[31:0];
        rc_r <= 8'h01;
        rk_mem[0] <= {key_high_r, key_low_r};
      end else begin
        w1_r <= w2_r; w2_r <= w3_r; w3_r <= w4_r; w4_r <= kword;
        if (kidx_r[1:0] == 2'd0) rc_r <= xtime(rc_r);
        rk_mem[kidx_r[5:2]][{~kidx_r[1:0], 5'd0} +: 32] <= kword;
      end
    end
  end

  // Round key fetch, one round key read from the schedule store each cycle.
  always_ff @(posedge clk) begin
    rkey_r <= rk_mem[rk_sel];
  end

  // Shared round unit; every round ends with its key addition.
  always_comb begin
    if (direction_r) round_out = dec_round(state_r, rnd_r != 4'd1) ^ rkey_r;
    else             round_out = enc_round(state_r, rnd_r != 4'd10) ^ rkey_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_KEYEXP; rnd_r <= '0; kidx_r <= '0; chain_r <= '0;
    end else begin
      st_r <= st_nxt; rnd_r <= rnd_nxt; kidx_r <= kidx_nxt; chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt; in_blk_r <= in_blk_nxt; prev_r <= prev_nxt;
  end

  // Sequencer for key expansion and the round iterations.
  always_comb begin
    logic [127:0] blk, prv;
    st_nxt = st_r; rnd_nxt = rnd_r; kidx_nxt = kidx_r; chain_nxt = chain_r;
    state_nxt = state_r; in_blk_nxt = in_blk_r; prev_nxt = prev_r;
    in_ready = 1'b0; out_valid = 1'b0;
    rk_sel = direction_r ? 4'd10 : 4'd0;
    blk = {in_data.block_high, in_data.block_low};
    prv = in_data.first_block ? {iv_high_r, iv_low_r} : chain_r;
    case (st_r)
      ST_KEYEXP: begin
        if (kidx_r == 6'd0) kidx_nxt = 6'd4;
        else if (kidx_r == 6'd43) begin
          kidx_nxt = '0; st_nxt = ST_IDLE;
        end else kidx_nxt = kidx_r + 6'd1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        rk_sel = direction_r ? 4'd10 : 4'd0;
        if (in_valid) begin
          in_blk_nxt = blk;
          prev_nxt = prv;
          state_nxt = (chaining_r && !direction_r) ? (blk ^ prv) : blk;
          rnd_nxt = 4'd0;
          st_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        // Round 0 is the first key addition; rounds 1..10 use the round unit.
        if (rnd_r == 4'd0) begin
          rk_sel = direction_r ? 4'd9 : 4'd1;
          state_nxt = state_r ^ rkey_r;
          rnd_nxt = 4'd1;
        end else begin
          if (rnd_r != 4'd10) rk_sel = direction_r ? (4'd9 - rnd_r) : (rnd_r + 4'd1);
          state_nxt = round_out;
          if (rnd_r == 4'd10) st_nxt = ST_DONE;
          rnd_nxt = rnd_r + 4'd1;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          st_nxt = ST_IDLE;
          if (chaining_r) chain_nxt = direction_r ? in_blk_r : state_r;
        end
      end
      default: st_nxt = ST_KEYEXP;
    endcase
    if (key_write) begin
      st_nxt = ST_KEYEXP; kidx_nxt = '0;
    end
  end

  assign out_data = (chaining_r && direction_r) ? (state_r ^ prev_r) : state_r;

endmodule
`default_nettype wire

[design/aes_checker.sv]
// Port-level checks for the AES engine, bound to the top level.
`default_nettype none
module aes_checker (
  input wire clk,
  input wire rst_n,
  input wire in_valid,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready,
  input wire aes_pkg::aes_out_t out_data
);
  import aes_pkg::*;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while result pending");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result dropped");
endmodule

bind aes128_block_cipher_ecb_cbc aes_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
